>>> design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is low
`define ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bre: same-cycle check failed");

// next-cycle implication, masked while reset is low
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bre: next-cycle check failed");

`endif

>>> design/bre_pkg.sv
package bre_pkg;

  localparam int NBITS_DEF  = 4096;
  localparam int MODE_W     = 4;
  localparam int START_W    = 12;
  localparam int COUNT_W    = 13;
  localparam int RESULT_W   = 13;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;
  // bit index wide enough for start + count
  localparam int IDX_W      = 14;
  localparam int BYTE_W     = IDX_W - 3;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_SET       = 4'd0;
  localparam mode_t MODE_CLR       = 4'd1;
  localparam mode_t MODE_RD        = 4'd2;
  localparam mode_t MODE_SET_RANGE = 4'd3;
  localparam mode_t MODE_CLR_RANGE = 4'd4;
  localparam mode_t MODE_COUNT     = 4'd5;
  localparam mode_t MODE_FIND_SET  = 4'd6;
  localparam mode_t MODE_FIND_CLR  = 4'd7;
  localparam mode_t MODE_REVERSE   = 4'd8;
  localparam mode_t MODE_CLR_ALL   = 4'd9;
  localparam mode_t MODE_INV_ALL   = 4'd10;

  // byte operation applied by the sweep
  typedef enum logic [2:0] {
    OP_SET,
    OP_CLR,
    OP_INV,
    OP_CNT,
    OP_FIND
  } op_t;

  // bits lo..hi of a byte, position 0 being the msb
  function automatic logic [7:0] span_mask(input logic [2:0] lo, input logic [2:0] hi);
    return (8'hFF >> lo) & (8'hFF << (3'd7 - hi));
  endfunction

  function automatic logic [3:0] pop8(input logic [7:0] d);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) n = n + {3'd0, d[i]};
    return n;
  endfunction

  // position of the first set bit counted from the msb
  function automatic logic [2:0] lead_pos(input logic [7:0] d);
    logic [2:0] p;
    p = 3'd0;
    for (int i = 0; i < 8; i++) if (d[i]) p = 3'(7 - i);
    return p;
  endfunction

endpackage

>>> design/bitmap_range_engine.sv
// bitmap range engine: a bitmap of NBITS bits held in a byte-wide synchronous
// memory, bit 0 being the msb of byte 0. each input transfer carries a mode,
// a start index and a count, and produces exactly one result transfer with a
// result value and a range error flag. after reset a clearing pass writes
// zero to every byte, during which in_tready stays low. the engine handles
// one request at a time. single-bit, range, count, find and whole-byte
// clear/invert requests sweep the covered bytes through a read-modify-write
// loop on the memory, one byte per cycle; finds stop at the first hit.
// reverse swaps one pair of bits per pass through the memory, with a second
// write-back when the two bits lie in different bytes. errors, zero counts
// and unused modes go straight to the result. the result sits in an output
// register, so a finished result waiting for out_tready only holds the
// engine back when the next one is ready too.
module bitmap_range_engine #(
  parameter int NBITS = bre_pkg::NBITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [3:0] mode, [15:4] start_index, [28:16] bit_count, [31:29] zero
  input  logic [bre_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [12:0] result_value, [13] range_error, [15:14] zero
  output logic [bre_pkg::OUT_DATA_W-1:0] out_tdata
);
  import bre_pkg::*;

  localparam int STORE_BYTES = (NBITS + 7) / 8;
  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

  typedef enum logic [6:0] {
    S_INIT    = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_SWEEP   = 7'b0000100,
    S_REV_RD  = 7'b0001000,
    S_REV_MOD = 7'b0010000,
    S_REV_WB  = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  // byte store
  logic [7:0] mem [STORE_BYTES];
  logic          we;
  logic [AW-1:0] wa, ra, rb;
  logic [7:0]    wd;
  logic [7:0]    rd_a_r, rd_b_r;

  // control
  state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic pvalid_r, pvalid_nxt;
  logic out_valid_r, out_valid_nxt;

  // request context and datapath
  op_t                 op_r, op_nxt;
  logic                want_r, want_nxt;
  logic                iss_done_r, iss_done_nxt;
  logic [BYTE_W-1:0]   k_r, k_nxt;        // next byte to read
  logic [BYTE_W-1:0]   pk_r, pk_nxt;      // byte whose data is in rd_a_r
  logic [BYTE_W-1:0]   first_r, first_nxt;
  logic [BYTE_W-1:0]   last_r, last_nxt;
  logic [2:0]          lo_r, lo_nxt;
  logic [2:0]          hi_r, hi_nxt;
  logic [RESULT_W-1:0] acc_r, acc_nxt;
  logic [RESULT_W-1:0] lim_r, lim_nxt;
  logic [RESULT_W-1:0] res_r, res_nxt;
  logic                err_r, err_nxt;
  logic [IDX_W-1:0]    a_r, a_nxt, b_r, b_nxt;
  logic [BYTE_W-1:0]   hb_r, hb_nxt;
  logic [7:0]          hold_r, hold_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // input fields
  mode_t              in_mode;
  logic [START_W-1:0] in_start;
  logic [COUNT_W-1:0] in_count;
  logic [IDX_W-1:0]   start_x, cnt_x, end_x, lim_x;
  logic               bit_bad, range_bad, lim_bad;

  assign in_mode  = in_tdata[3:0];
  assign in_start = in_tdata[15:4];
  assign in_count = in_tdata[28:16];
  assign start_x  = IDX_W'(in_start);
  assign cnt_x    = IDX_W'(in_count);
  assign end_x    = start_x + cnt_x - IDX_W'(1);
  assign lim_x    = cnt_x - IDX_W'(1);
  assign bit_bad   = 32'(in_start) >= 32'(NBITS);
  assign range_bad = (32'(start_x) + 32'(cnt_x)) > 32'(NBITS);
  assign lim_bad   = 32'(in_count) > 32'(NBITS);

  // sweep byte datapath
  logic [2:0]          lo_k, hi_k;
  logic [7:0]          mask, hit_vec;
  logic [RESULT_W-1:0] acc_add, find_idx;

  assign lo_k     = (pk_r == first_r) ? lo_r : 3'd0;
  assign hi_k     = (pk_r == last_r) ? hi_r : 3'd7;
  assign mask     = span_mask(lo_k, hi_k);
  assign hit_vec  = (want_r ? rd_a_r : ~rd_a_r) & mask;
  assign acc_add  = acc_r + RESULT_W'(pop8(rd_a_r & mask));
  assign find_idx = RESULT_W'({pk_r, lead_pos(hit_vec)});

  // reverse pair datapath
  logic [2:0]       pa, pb;
  logic             va, vb, same;
  logic [7:0]       na, nb;
  logic [IDX_W-1:0] a_inc, b_dec;

  assign pa    = 3'd7 - a_r[2:0];
  assign pb    = 3'd7 - b_r[2:0];
  assign va    = rd_a_r[pa];
  assign vb    = rd_b_r[pb];
  assign same  = a_r[IDX_W-1:3] == b_r[IDX_W-1:3];
  assign a_inc = a_r + IDX_W'(1);
  assign b_dec = b_r - IDX_W'(1);

  always_comb begin
    na = rd_a_r;
    na[pa] = vb;
    if (same) na[pb] = va;
    nb = rd_b_r;
    nb[pb] = va;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    pvalid_nxt    = pvalid_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    want_nxt      = want_r;
    iss_done_nxt  = iss_done_r;
    k_nxt         = k_r;
    pk_nxt        = pk_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    acc_nxt       = acc_r;
    lim_nxt       = lim_r;
    res_nxt       = res_r;
    err_nxt       = err_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    hb_nxt        = hb_r;
    hold_nxt      = hold_r;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    wa            = AW'(pk_r);
    wd            = 8'h00;
    ra            = AW'(k_r);
    rb            = AW'(b_r[IDX_W-1:3]);

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_INIT: begin
        // clearing pass after reset
        we = 1'b1;
        wa = clr_r;
        if (clr_r == LAST_ADDR) state_nxt = S_IDLE;
        else clr_nxt = clr_r + AW'(1);
      end

      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt    = S_DONE;
          res_nxt      = '0;
          err_nxt      = 1'b0;
          acc_nxt      = '0;
          pvalid_nxt   = 1'b0;
          iss_done_nxt = 1'b0;
          first_nxt    = start_x[IDX_W-1:3];
          k_nxt        = start_x[IDX_W-1:3];
          lo_nxt       = start_x[2:0];
          unique case (in_mode)
            MODE_SET, MODE_CLR, MODE_RD: begin
              if (bit_bad) begin
                err_nxt = 1'b1;
              end else begin
                op_nxt    = (in_mode == MODE_SET) ? OP_SET :
                            (in_mode == MODE_CLR) ? OP_CLR : OP_CNT;
                last_nxt  = start_x[IDX_W-1:3];
                hi_nxt    = start_x[2:0];
                state_nxt = S_SWEEP;
              end
            end
            MODE_SET_RANGE, MODE_CLR_RANGE, MODE_COUNT: begin
              if (in_count != '0) begin
                if (range_bad) begin
                  err_nxt = 1'b1;
                end else begin
                  op_nxt    = (in_mode == MODE_SET_RANGE) ? OP_SET :
                              (in_mode == MODE_CLR_RANGE) ? OP_CLR : OP_CNT;
                  last_nxt  = end_x[IDX_W-1:3];
                  hi_nxt    = end_x[2:0];
                  state_nxt = S_SWEEP;
                end
              end
            end
            MODE_FIND_SET, MODE_FIND_CLR: begin
              if (lim_bad) begin
                err_nxt = 1'b1;
              end else if (start_x >= cnt_x) begin
                // search starts at or past the limit
                res_nxt = in_count;
              end else begin
                op_nxt    = OP_FIND;
                want_nxt  = (in_mode == MODE_FIND_SET);
                lim_nxt   = in_count;
                last_nxt  = lim_x[IDX_W-1:3];
                hi_nxt    = lim_x[2:0];
                state_nxt = S_SWEEP;
              end
            end
            MODE_REVERSE: begin
              if (in_count != '0) begin
                if (range_bad) begin
                  err_nxt = 1'b1;
                end else if (in_count != COUNT_W'(1)) begin
                  a_nxt     = start_x;
                  b_nxt     = end_x;
                  state_nxt = S_REV_RD;
                end
              end
            end
            MODE_CLR_ALL, MODE_INV_ALL: begin
              if (in_count != '0) begin
                if (lim_bad) begin
                  err_nxt = 1'b1;
                end else begin
                  // whole bytes from byte 0
                  op_nxt    = (in_mode == MODE_CLR_ALL) ? OP_CLR : OP_INV;
                  first_nxt = '0;
                  k_nxt     = '0;
                  lo_nxt    = 3'd0;
                  hi_nxt    = 3'd7;
                  last_nxt  = lim_x[IDX_W-1:3];
                  state_nxt = S_SWEEP;
                end
              end
            end
            default: begin
              // unused modes answer zero
            end
          endcase
        end
      end

      S_SWEEP: begin
        // read side: one byte a cycle up to the last one
        if (!iss_done_r) begin
          pvalid_nxt = 1'b1;
          pk_nxt     = k_r;
          if (k_r == last_r) iss_done_nxt = 1'b1;
          else k_nxt = k_r + BYTE_W'(1);
        end else begin
          pvalid_nxt = 1'b0;
        end
        // modify and write back, or count or search, the byte read last cycle
        if (pvalid_r) begin
          unique case (op_r)
            OP_SET: begin
              we = 1'b1;
              wd = rd_a_r | mask;
            end
            OP_CLR: begin
              we = 1'b1;
              wd = rd_a_r & ~mask;
            end
            OP_INV: begin
              we = 1'b1;
              wd = rd_a_r ^ mask;
            end
            OP_CNT:  acc_nxt = acc_add;
            OP_FIND: ;
            default: ;
          endcase
          if (op_r == OP_FIND && hit_vec != 8'h00) begin
            res_nxt    = find_idx;
            pvalid_nxt = 1'b0;
            state_nxt  = S_DONE;
          end else if (pk_r == last_r) begin
            res_nxt    = (op_r == OP_CNT) ? acc_add :
                         (op_r == OP_FIND) ? lim_r : '0;
            pvalid_nxt = 1'b0;
            state_nxt  = S_DONE;
          end
        end
      end

      S_REV_RD: begin
        ra        = AW'(a_r[IDX_W-1:3]);
        state_nxt = S_REV_MOD;
      end

      S_REV_MOD: begin
        // swap the pair; a second write is needed when the bytes differ
        we       = 1'b1;
        wa       = AW'(a_r[IDX_W-1:3]);
        wd       = na;
        hold_nxt = nb;
        hb_nxt   = b_r[IDX_W-1:3];
        a_nxt    = a_inc;
        b_nxt    = b_dec;
        if (!same) state_nxt = S_REV_WB;
        else if (a_inc < b_dec) state_nxt = S_REV_RD;
        else state_nxt = S_DONE;
      end

      S_REV_WB: begin
        we        = 1'b1;
        wa        = AW'(hb_r);
        wd        = hold_r;
        state_nxt = (a_r < b_r) ? S_REV_RD : S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({err_r, res_r});
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_a_r <= mem[ra];
    rd_b_r <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_r       <= '0;
      pvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pvalid_r    <= pvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    want_r     <= want_nxt;
    iss_done_r <= iss_done_nxt;
    k_r        <= k_nxt;
    pk_r       <= pk_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    acc_r      <= acc_nxt;
    lim_r      <= lim_nxt;
    res_r      <= res_nxt;
    err_r      <= err_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    hb_r       <= hb_nxt;
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> design/bre_checker.sv
`include "assert_macros.svh"

module bre_checker #(
  parameter int NBITS = bre_pkg::NBITS_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [bre_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [bre_pkg::OUT_DATA_W-1:0] out_tdata
);
  import bre_pkg::*;

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready && (in_tdata[3:0] <= MODE_INV_ALL);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // an error result carries a zero value
  `ASSERT_NOW(a_err_zero, clk, rst_n, out_tvalid && out_tdata[RESULT_W], out_tdata[RESULT_W-1:0] == '0)

  // one request at a time: no second transfer straight after one
  `ASSERT_NEXT(a_one_req, clk, rst_n, in_xfer, !in_tready)

  // no result ever exceeds the bitmap size
  `ASSERT_NOW(a_res_bound, clk, rst_n, out_tvalid, 32'(out_tdata[RESULT_W-1:0]) <= 32'(NBITS))

endmodule

bind bitmap_range_engine bre_checker #(.NBITS(NBITS)) u_bre_checker (.*);
